// ----- rtl/core/mthd_pkg.sv -----
package mthd_pkg;

	// slot count fixed by the 4-bit target index
	localparam int NUM_SLOTS = 16;

	localparam logic [11:0] FULL_SCALE      = 12'hFFF;
	localparam logic [12:0] HIT_LEVEL_RESET = 13'd2048;
	localparam logic [12:0] DARK_RESET      = 13'd0;
	localparam logic [12:0] LIT_RESET       = 13'd4096;
	localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

	localparam logic [9:0]  REFRESH_STEP_RESET   = 10'd10;
	localparam logic [15:0] HIT_TIME_LIMIT_RESET = 16'd100;

	// configuration register indexes
	localparam logic CFG_REFRESH_STEP   = 1'b0;
	localparam logic CFG_HIT_TIME_LIMIT = 1'b1;

	typedef enum logic [2:0] {
		MODE_SCAN      = 3'd0,
		MODE_CAL_DARK  = 3'd1,
		MODE_CAL_LIT   = 3'd2,
		MODE_ENABLE    = 3'd3,
		MODE_THRESHOLD = 3'd4,
		MODE_PROBE     = 3'd5
	} mode_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [3:0]  target_index;
		logic [11:0] sample;
		logic [12:0] value;
	} item_t;

	typedef struct packed {
		logic [12:0] hit_level;
		logic [12:0] dark_level;
		logic [12:0] lit_level;
		logic [15:0] count;
		logic        armed;
		logic        present;
	} entry_t;

	typedef struct packed {
		logic [19:0] sum;
		logic [8:0]  count;
	} cal_t;

	typedef struct packed {
		logic        hit;
		logic [3:0]  hit_target;
		logic [12:0] threshold_now;
		logic        cal_done;
		logic [11:0] cal_average;
		logic        target_enabled;
		logic        target_connected;
	} result_t;

	// state write-back from the update logic
	typedef struct packed {
		logic   entry_we;
		logic   cal_we;
		entry_t entry;
		cal_t   cal;
	} update_t;

endpackage

// ----- rtl/core/multi_target_hit_detector_core.sv -----
// channel   dir  handshake                  payload
// s_axis    in   s_tvalid / s_tready        s_tuser mode, s_tdata index/sample/value
// m_axis    out  m_tvalid / m_tready        m_tdata one result per input beat
// cfg       in   cfg_we (no wait)           cfg_index, cfg_data
//
// one beat per cycle unless the output stalls; each beat is held in the input register,
// where the target's entry is read, updated and written back as the result is registered.
// each result passes from the input register into the result register that drives m_tdata.
// a stalled output holds its result and the input register fills behind it.
// active-low async reset loads entry and config defaults and clears cal and valid bits.
module multi_target_hit_detector_core
	import mthd_pkg::*;
#(
	parameter int TARGET_COUNT     = 10,
	parameter int CAL_SAMPLES_LOG2 = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // target_index[3:0], sample[15:4], value[28:16], zero pad
	input  logic [2:0]  s_tuser,  // mode[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // hit[0], hit_target[4:1], threshold_now[17:5],
	                              // cal_done[18], cal_average[30:19], target_enabled[31],
	                              // target_connected[32], zero pad
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	item_t       item_s1;
	logic        valid_s1;
	result_t     out_q;
	logic        out_valid_q;
	logic [9:0]  refresh_step_q;
	logic [15:0] hit_time_limit_q;

	logic [12:0] hit_level_q  [NUM_SLOTS];
	logic [12:0] dark_level_q [NUM_SLOTS];
	logic [12:0] lit_level_q  [NUM_SLOTS];
	logic [15:0] count_q      [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] armed_q;
	logic [NUM_SLOTS-1:0] present_q;
	cal_t        cal_q;

	logic        advance;
	entry_t      cur;
	update_t     upd;
	result_t     res;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.mode         <= s_tuser;
			item_s1.target_index <= s_tdata[3:0];
			item_s1.sample       <= s_tdata[15:4];
			item_s1.value        <= s_tdata[28:16];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_step_q   <= REFRESH_STEP_RESET;
			hit_time_limit_q <= HIT_TIME_LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REFRESH_STEP:   refresh_step_q   <= cfg_data[9:0];
				CFG_HIT_TIME_LIMIT: hit_time_limit_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// read of the addressed entry
	always_comb begin
		cur.hit_level  = hit_level_q[item_s1.target_index];
		cur.dark_level = dark_level_q[item_s1.target_index];
		cur.lit_level  = lit_level_q[item_s1.target_index];
		cur.count      = count_q[item_s1.target_index];
		cur.armed      = armed_q[item_s1.target_index];
		cur.present    = present_q[item_s1.target_index];
	end

	mthd_step #(
		.TARGET_COUNT     (TARGET_COUNT),
		.CAL_SAMPLES_LOG2 (CAL_SAMPLES_LOG2)
	) u_step (
		.item           (item_s1),
		.cur            (cur),
		.cal            (cal_q),
		.refresh_step   (refresh_step_q),
		.hit_time_limit (hit_time_limit_q),
		.upd            (upd),
		.res            (res)
	);

	// target entry and calibration accumulator write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				hit_level_q[i]  <= HIT_LEVEL_RESET;
				dark_level_q[i] <= DARK_RESET;
				lit_level_q[i]  <= LIT_RESET;
				count_q[i]      <= 16'd0;
			end
			armed_q   <= '0;
			present_q <= '0;
			cal_q     <= '0;
		end else if (advance) begin
			if (upd.entry_we) begin
				hit_level_q[item_s1.target_index]  <= upd.entry.hit_level;
				dark_level_q[item_s1.target_index] <= upd.entry.dark_level;
				lit_level_q[item_s1.target_index]  <= upd.entry.lit_level;
				count_q[item_s1.target_index]      <= upd.entry.count;
				armed_q[item_s1.target_index]      <= upd.entry.armed;
				present_q[item_s1.target_index]    <= upd.entry.present;
			end
			if (upd.cal_we) begin
				cal_q <= upd.cal;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q.target_connected, out_q.target_enabled, out_q.cal_average,
		out_q.cal_done, out_q.threshold_now, out_q.hit_target, out_q.hit};

endmodule

// ----- rtl/core/mthd_step.sv -----
module mthd_step
	import mthd_pkg::*;
#(
	parameter int TARGET_COUNT     = 10,
	parameter int CAL_SAMPLES_LOG2 = 4
) (
	input  item_t       item,
	input  entry_t      cur,
	input  cal_t        cal,
	input  logic [9:0]  refresh_step,
	input  logic [15:0] hit_time_limit,
	output update_t     upd,
	output result_t     res
);

	localparam logic [8:0] CAL_TARGET = 9'(1 << CAL_SAMPLES_LOG2);

	function automatic logic [12:0] midpoint(input logic [12:0] lo, input logic [12:0] hi);
		logic [12:0] d;
		begin
			if (hi >= lo) begin
				d = hi - lo;
				midpoint = lo + (d >> 1);
			end else begin
				d = lo - hi;
				midpoint = lo - (d >> 1);
			end
		end
	endfunction

	logic        in_range;
	logic [16:0] count_sum;
	logic [19:0] sum_next;
	logic [8:0]  cnt_next;
	logic [19:0] sum_shift;
	logic [11:0] avg;
	entry_t      nxt;
	cal_t        cal_nxt;
	logic        hit;
	logic        done;

	assign in_range  = 32'(item.target_index) < TARGET_COUNT;
	assign count_sum = {1'b0, cur.count} + {7'd0, refresh_step};
	assign sum_next  = cal.sum + {8'd0, item.sample};
	assign cnt_next  = cal.count + 9'd1;
	assign sum_shift = sum_next >> CAL_SAMPLES_LOG2;

	// per-mode update of the addressed entry and the calibration accumulator
	always_comb begin
		nxt     = cur;
		cal_nxt = cal;
		hit     = 1'b0;
		done    = 1'b0;
		avg     = 12'd0;
		case (mode_t'(item.mode))
			MODE_SCAN: begin
				if ({1'b0, item.sample} > cur.hit_level) begin
					nxt.count = count_sum[16] ? COUNT_MAX : count_sum[15:0];
				end else if (cur.count >= {6'd0, refresh_step}) begin
					nxt.count = cur.count - {6'd0, refresh_step};
				end
				if (cur.armed && nxt.count >= hit_time_limit) begin
					hit = 1'b1;
					if (cur.present) begin
						nxt.armed = 1'b0;
					end
				end
			end
			MODE_CAL_DARK, MODE_CAL_LIT: begin
				cal_nxt.sum   = sum_next;
				cal_nxt.count = cnt_next;
				if (cnt_next >= CAL_TARGET) begin
					avg           = sum_shift[11:0];
					done          = 1'b1;
					cal_nxt.sum   = 20'd0;
					cal_nxt.count = 9'd0;
					if (mode_t'(item.mode) == MODE_CAL_LIT) begin
						nxt.lit_level = {1'b0, avg};
					end else begin
						nxt.dark_level = {1'b0, avg};
					end
					nxt.hit_level = midpoint(nxt.dark_level, nxt.lit_level);
				end
			end
			MODE_ENABLE: begin
				if (cur.present) begin
					nxt.armed = item.value[0];
					if (item.value[0]) begin
						nxt.count = 16'd0;
					end
				end
			end
			MODE_THRESHOLD: begin
				nxt.hit_level = item.value;
			end
			MODE_PROBE: begin
				nxt.present = (item.sample == FULL_SCALE);
			end
			default: begin
			end
		endcase
	end

	assign upd.entry_we = in_range;
	assign upd.cal_we   = in_range;
	assign upd.entry    = nxt;
	assign upd.cal      = cal_nxt;

	// out-of-range targets report zeros apart from the index echo
	always_comb begin
		res.hit_target = item.target_index;
		if (in_range) begin
			res.hit              = hit;
			res.threshold_now    = nxt.hit_level;
			res.cal_done         = done;
			res.cal_average      = avg;
			res.target_enabled   = nxt.armed;
			res.target_connected = nxt.present;
		end else begin
			res.hit              = 1'b0;
			res.threshold_now    = 13'd0;
			res.cal_done         = 1'b0;
			res.cal_average      = 12'd0;
			res.target_enabled   = 1'b0;
			res.target_connected = 1'b0;
		end
	end

endmodule

// ----- test/multi_target_hit_detector_core_tb.sv -----
`timescale 1ns / 1ps

module multi_target_hit_detector_core_tb
	import mthd_pkg::*;
;

	localparam int NUM_TARGETS  = 10;
	localparam int CAL_LOG2     = 4;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 4;

	// modes the block has no operation for
	localparam logic [2:0] MODE_RESERVED_LO = 3'd6;
	localparam logic [2:0] MODE_RESERVED_HI = 3'd7;

	// one line of the directed table: either a register setting or an input beat
	typedef struct packed {
		bit          reconf;
		logic [9:0]  step;
		logic [15:0] limit;
		logic [2:0]  mode;
		logic [3:0]  idx;
		logic [11:0] adc;
		logic [12:0] val;
		bit          known;
		result_t     want;
	} row_t;

	// shape of one random phase
	typedef struct packed {
		logic [9:0]  step;
		logic [15:0] limit;
		int          items;
		int          focus;
		int          hi_pct;
		int          cal_pct;
		int          ctl_pct;
		bit          steady;
	} phase_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;  // target_index[3:0], sample[15:4], value[28:16], zero pad
	logic [2:0]  s_tuser;  // mode[2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;  // hit[0], hit_target[4:1], threshold_now[17:5], cal_done[18],
	                       // cal_average[30:19], target_enabled[31], target_connected[32]
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	// beat-side tag: typed-in expectation travels with the input beat
	bit          row_known;
	result_t     row_want;
	bit          steady = 1'b0;

	int items_sent   = 0;
	int results_seen = 0;
	int errors       = 0;
	int cycles       = 0;

	// predictor state, one entry per slot
	logic [12:0] lvl_hit [NUM_SLOTS];
	logic [12:0] lvl_dark [NUM_SLOTS];
	logic [12:0] lvl_lit [NUM_SLOTS];
	logic [15:0] exposure [NUM_SLOTS];
	bit          armed [NUM_SLOTS];
	bit          present [NUM_SLOTS];
	logic [19:0] cal_acc;
	logic [8:0]  cal_n;
	logic [9:0]  refresh;
	logic [15:0] hit_limit;

	result_t pending_results [$];
	result_t predicted;
	result_t got_res;
	result_t want_res;

	multi_target_hit_detector_core #(
		.TARGET_COUNT(NUM_TARGETS),
		.CAL_SAMPLES_LOG2(CAL_LOG2)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	task automatic check_field(string name, logic [12:0] got, logic [12:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
				results_seen, name, got, want));
		end
	endtask

	// one item through the detector: updates the slot and returns its result
	function automatic result_t detector_step(logic [2:0] mode, logic [3:0] t,
			logic [11:0] adc, logic [12:0] val);
		result_t r;
		int sum;
		int lo;
		int hi;
		r = '0;
		r.hit_target = t;
		if (t >= NUM_TARGETS) return r;
		case (mode)
		MODE_SCAN: begin
			// integrate up while lit, down while dark, never below zero
			if (adc > lvl_hit[t]) begin
				sum = exposure[t] + refresh;
				exposure[t] = (sum > COUNT_MAX) ? COUNT_MAX : sum[15:0];
			end else if (exposure[t] >= refresh) begin
				exposure[t] = exposure[t] - refresh;
			end
			// disarming needs a connected target, the hit is reported anyway
			if (armed[t] && exposure[t] >= hit_limit) begin
				r.hit = 1'b1;
				if (present[t]) armed[t] = 1'b0;
			end
		end
		MODE_CAL_DARK, MODE_CAL_LIT: begin
			// shared accumulator, the completing beat picks slot and level
			cal_acc = cal_acc + adc;
			cal_n = cal_n + 1'b1;
			if (cal_n >= (1 << CAL_LOG2)) begin
				r.cal_done = 1'b1;
				r.cal_average = 12'(cal_acc >> CAL_LOG2);
				cal_acc = '0;
				cal_n = '0;
				if (mode == MODE_CAL_LIT) lvl_lit[t] = {1'b0, r.cal_average};
				else lvl_dark[t] = {1'b0, r.cal_average};
				lo = lvl_dark[t];
				hi = lvl_lit[t];
				lvl_hit[t] = 13'((hi >= lo) ? lo + (hi - lo) / 2 : lo - (lo - hi) / 2);
			end
		end
		MODE_ENABLE: begin
			if (present[t]) begin
				armed[t] = val[0];
				if (val[0]) exposure[t] = '0;
			end
		end
		MODE_THRESHOLD: lvl_hit[t] = val;
		MODE_PROBE: present[t] = (adc == FULL_SCALE);
		default: ;
		endcase
		r.threshold_now = lvl_hit[t];
		r.target_enabled = armed[t];
		r.target_connected = present[t];
		return r;
	endfunction

	function automatic result_t want_of(bit hit, logic [3:0] tgt, logic [12:0] thr,
			bit en, bit con);
		result_t r;
		r = '0;
		r.hit = hit;
		r.hit_target = tgt;
		r.threshold_now = thr;
		r.target_enabled = en;
		r.target_connected = con;
		return r;
	endfunction

	function automatic row_t op(logic [2:0] mode, logic [3:0] idx, logic [11:0] adc,
			logic [12:0] val);
		row_t r;
		r = '0;
		r.mode = mode;
		r.idx = idx;
		r.adc = adc;
		r.val = val;
		return r;
	endfunction

	function automatic row_t op_known(logic [2:0] mode, logic [3:0] idx, logic [11:0] adc,
			logic [12:0] val, result_t want);
		row_t r;
		r = op(mode, idx, adc, val);
		r.known = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic row_t setting(logic [9:0] step, logic [15:0] limit);
		row_t r;
		r = '0;
		r.reconf = 1'b1;
		r.step = step;
		r.limit = limit;
		return r;
	endfunction

	function automatic phase_t phase(logic [9:0] step, logic [15:0] limit, int items,
			int focus, int hi_pct, int cal_pct, int ctl_pct, bit no_idle);
		phase_t p;
		p.step = step;
		p.limit = limit;
		p.items = items;
		p.focus = focus;
		p.hi_pct = hi_pct;
		p.cal_pct = cal_pct;
		p.ctl_pct = ctl_pct;
		p.steady = no_idle;
		return p;
	endfunction

	// present one input beat, with random idle cycles ahead of it unless steady is set
	task automatic send_item(logic [2:0] mode, logic [3:0] idx, logic [11:0] adc,
			logic [12:0] val, bit known, result_t want);
		while (!steady && $urandom_range(0, 99) < 25) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {3'b000, val, adc, idx};
		row_known <= known;
		row_want <= want;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	// drain every result, let the pipe settle, then write both registers
	task automatic apply_setting(logic [9:0] step, logic [15:0] limit);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_seen != items_sent) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_REFRESH_STEP;
		cfg_data <= 16'(step);
		@(posedge clk);
		cfg_index <= CFG_HIT_TIME_LIMIT;
		cfg_data <= limit;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// predictor and result checker
	always @(posedge clk) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				lvl_hit[i] = HIT_LEVEL_RESET;
				lvl_dark[i] = DARK_RESET;
				lvl_lit[i] = LIT_RESET;
				exposure[i] = '0;
				armed[i] = 1'b0;
				present[i] = 1'b0;
			end
			cal_acc = '0;
			cal_n = '0;
			refresh = REFRESH_STEP_RESET;
			hit_limit = HIT_TIME_LIMIT_RESET;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_REFRESH_STEP) refresh = cfg_data[9:0];
				else hit_limit = cfg_data;
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with nothing expected",
						results_seen));
				end else begin
					want_res = pending_results.pop_front();
					got_res.hit = m_tdata[0];
					got_res.hit_target = m_tdata[4:1];
					got_res.threshold_now = m_tdata[17:5];
					got_res.cal_done = m_tdata[18];
					got_res.cal_average = m_tdata[30:19];
					got_res.target_enabled = m_tdata[31];
					got_res.target_connected = m_tdata[32];
					check_field("hit", got_res.hit, want_res.hit);
					check_field("hit_target", got_res.hit_target, want_res.hit_target);
					check_field("threshold_now", got_res.threshold_now, want_res.threshold_now);
					check_field("cal_done", got_res.cal_done, want_res.cal_done);
					check_field("cal_average", got_res.cal_average, want_res.cal_average);
					check_field("target_enabled", got_res.target_enabled,
						want_res.target_enabled);
					check_field("target_connected", got_res.target_connected,
						want_res.target_connected);
					check_field("pad", m_tdata[39:33], '0);
				end
			end
			if (s_tvalid && s_tready) begin
				predicted = detector_step(s_tuser, s_tdata[3:0], s_tdata[15:4], s_tdata[28:16]);
				pending_results.push_back(row_known ? row_want : predicted);
			end
		end
	end

	// output back-pressure
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			m_tready <= steady || ($urandom_range(0, 99) >= 25);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("multi_target_hit_detector_core_tb: errors");
			$finish;
		end
	end

	// stimulus
	initial begin
		row_t directed [$];
		phase_t plan [7];
		phase_t cur;
		logic [2:0] mode;
		logic [3:0] idx;
		logic [11:0] adc;
		logic [12:0] val;
		int pick;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_REFRESH_STEP;
		cfg_data = '0;
		row_known = 1'b0;
		row_want = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed table, reset register values until the first setting line
		directed = '{
			op_known(MODE_SCAN, 0, 0, 0, want_of(0, 0, 2048, 0, 0)),
			op_known(MODE_SCAN, 15, FULL_SCALE, 4096, want_of(0, 15, 0, 0, 0)),
			op_known(MODE_SCAN, 10, FULL_SCALE, 0, want_of(0, 10, 0, 0, 0)),
			op_known(MODE_RESERVED_HI, 9, FULL_SCALE, 4096, want_of(0, 9, 2048, 0, 0)),
			op_known(MODE_RESERVED_LO, 3, 0, 0, want_of(0, 3, 2048, 0, 0)),
			op_known(MODE_ENABLE, 2, 0, 1, want_of(0, 2, 2048, 0, 0)),
			op_known(MODE_PROBE, 2, 12'hFFE, 0, want_of(0, 2, 2048, 0, 0)),
			op_known(MODE_PROBE, 2, FULL_SCALE, 0, want_of(0, 2, 2048, 0, 1)),
			op_known(MODE_ENABLE, 2, 0, 1, want_of(0, 2, 2048, 1, 1)),
			op_known(MODE_THRESHOLD, 2, 0, 4096, want_of(0, 2, 4096, 1, 1)),
			op_known(MODE_SCAN, 2, FULL_SCALE, 0, want_of(0, 2, 4096, 1, 1)),
			op_known(MODE_THRESHOLD, 2, 0, 0, want_of(0, 2, 0, 1, 1)),
			setting(10, 1),
			op_known(MODE_SCAN, 2, 1, 0, want_of(1, 2, 0, 0, 1)),
			op_known(MODE_SCAN, 2, 1, 0, want_of(0, 2, 0, 0, 1)),
			op(MODE_PROBE, 1, FULL_SCALE, 0),
			op(MODE_ENABLE, 1, 0, 4095),
			op(MODE_PROBE, 1, 0, 0),
			op_known(MODE_SCAN, 1, FULL_SCALE, 0, want_of(1, 1, 2048, 1, 0)),
			op(MODE_SCAN, 1, 0, 0),
			setting(1023, 65535),
			op(MODE_SCAN, 9, FULL_SCALE, 0),
			op_known(MODE_ENABLE, 9, 0, 0, want_of(0, 9, 2048, 0, 0)),
			op(MODE_CAL_DARK, 9, FULL_SCALE, 0),
			op(MODE_CAL_LIT, 0, 0, 0)
		};
		foreach (directed[i]) begin
			if (directed[i].reconf) apply_setting(directed[i].step, directed[i].limit);
			else send_item(directed[i].mode, directed[i].idx, directed[i].adc,
				directed[i].val, directed[i].known, directed[i].want);
		end

		// random phases: settings, target focus and operation mix
		plan[0] = phase(10, 100, 160, 3, 70, 12, 20, 1'b0);
		plan[1] = phase(1, 1, 120, 4, 50, 10, 24, 1'b1);
		plan[2] = phase(1023, 65535, 150, 1, 95, 2, 2, 1'b0);
		plan[3] = phase(1023, 1, 100, 4, 50, 10, 24, 1'b0);
		plan[4] = phase(10'($urandom_range(1, 1023)), 16'($urandom_range(1, 2000)), 130, 3,
			60, 40, 16, 1'b0);
		plan[5] = phase(1, 65535, 80, 2, 70, 20, 16, 1'b0);
		plan[6] = phase(10'($urandom_range(1, 1023)), 16'($urandom_range(1, 65535)), 60, 3,
			60, 15, 20, 1'b0);
		foreach (plan[p]) begin
			cur = plan[p];
			apply_setting(cur.step, cur.limit);
			steady = cur.steady;
			for (int n = 0; n < cur.items; n++) begin
				// mostly the focus slots, some other valid slots, a few out of range
				pick = $urandom_range(0, 99);
				if (pick < 80) idx = 4'($urandom_range(0, cur.focus - 1));
				else if (pick < 95) idx = 4'($urandom_range(0, NUM_TARGETS - 1));
				else idx = 4'($urandom_range(NUM_TARGETS, NUM_SLOTS - 1));
				adc = 12'($urandom_range(0, 4095));
				val = 13'($urandom_range(0, 4096));
				pick = $urandom_range(0, 99);
				if (n < 2 * cur.focus) begin
					// connect then arm each focus slot
					idx = 4'(n / 2);
					mode = (n % 2) ? MODE_ENABLE : MODE_PROBE;
					adc = FULL_SCALE;
					val[0] = 1'b1;
				end else if (pick < cur.cal_pct) begin
					mode = $urandom_range(0, 1) ? MODE_CAL_LIT : MODE_CAL_DARK;
				end else if (pick < cur.cal_pct + cur.ctl_pct) begin
					pick = $urandom_range(0, 9);
					if (pick < 4) begin
						mode = MODE_PROBE;
						if ($urandom_range(0, 3) != 0) adc = FULL_SCALE;
					end else if (pick < 7) begin
						mode = MODE_ENABLE;
						if ($urandom_range(0, 4) != 0) val[0] = 1'b1;
					end else if (pick < 9) begin
						mode = MODE_THRESHOLD;
						if ($urandom_range(0, 4) < 3) val = 13'($urandom_range(0, 3000));
					end else begin
						mode = $urandom_range(0, 1) ? MODE_RESERVED_HI : MODE_RESERVED_LO;
					end
				end else begin
					mode = MODE_SCAN;
					if ($urandom_range(0, 99) < cur.hi_pct) adc = FULL_SCALE;
					else if ($urandom_range(0, 9) == 0) adc = '0;
				end
				send_item(mode, idx, adc, val, 1'b0, '0);
			end
		end
		steady = 1'b0;

		// wait out the last results
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_seen != items_sent) @(posedge clk);
		repeat (2 * DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		end
		if (errors == 0) $display("multi_target_hit_detector_core_tb: clean");
		else $display("multi_target_hit_detector_core_tb: errors");
		$finish;
	end

endmodule
